// ----- rtl/core/plbl_pkg.sv -----
`timescale 1ns / 1ps

package plbl_pkg;

  // Fixed constants of the bucket arithmetic.
  localparam logic [31:0] IDLE_MS       = 32'd60000;
  localparam logic [31:0] ONE_REQ       = 32'd1000;
  localparam logic [1:0]  EXPIRE_ROUNDS = 2'd3;
  localparam logic [29:0] W30_MAX       = 30'h3FFF_FFFF;
  localparam logic [31:0] DELAY_MAX     = 32'hFFFF_FFFF;

  // Reciprocals of 1000: ceil(2^30 / 1000) for a 20-bit dividend and
  // ceil(2^40 / 1000) for a 30-bit dividend.
  localparam logic [20:0] RECIP_HI      = 21'd1073742;
  localparam logic [30:0] RECIP_LO      = 31'd1099511628;

  // Result verdict codes.
  typedef enum logic [2:0] {
    VERDICT_SKIP   = 3'd0,
    VERDICT_NEW    = 3'd1,
    VERDICT_PASS   = 3'd2,
    VERDICT_NODLY  = 3'd3,
    VERDICT_DELAY  = 3'd4,
    VERDICT_REJECT = 3'd5
  } verdict_e;

  // Configuration register indexes (byte address is four times this).
  typedef enum logic [1:0] {
    REG_ENABLED  = 2'd0,
    REG_RATE     = 2'd1,
    REG_BURST    = 2'd2,
    REG_NO_DELAY = 2'd3
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXP_BEGIN,
    ST_EXP_CHK,
    ST_EXP_CMP,
    ST_SCAN,
    ST_HIT_MUL,
    ST_HIT_Z,
    ST_HIT_Q1,
    ST_HIT_Q2,
    ST_DIV_LOAD,
    ST_DIV,
    ST_HIT_E,
    ST_TOUCH_A,
    ST_TOUCH_B,
    ST_TOUCH_C,
    ST_TOUCH_D,
    ST_DECIDE,
    ST_DELAY_MUL,
    ST_DELAY_END,
    ST_INSERT,
    ST_INSERT_LINK,
    ST_OUT
  } state_e;

  // Magnitude of the wrapping time difference read as a signed value.
  function automatic logic [31:0] elapsed_abs(input logic [31:0] now_v,
                                              input logic [31:0] last_v);
    logic [31:0] d;
    d = now_v - last_v;
    return d[31] ? (~d + 32'd1) : d;
  endfunction

endpackage

// ----- rtl/core/per_key_leaky_bucket_limiter.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | Handshake             | Payload
// s_axis    | in        | tvalid/tready         | tdata: key, now_ms; tuser: key_present
// m_axis    | out       | tvalid/tready         | tdata: verdict, excess_out, delay_ms
// apb       | in/out    | psel/penable, pready  | four registers at 0x0, 0x4, 0x8, 0xC
//
// A request with a key on an enabled block runs expiry checks on the oldest entries,
// then a scan of the table, then the output. A hit adds the bucket math and the
// recency update, and a delay verdict adds the 64-step division by the rate. A
// miss in a full table forces the oldest entry out before the insert. Reset is
// asynchronous and clears the valid bits at once. The input is taken in idle while
// an earlier result may still wait in the output register; a new result waits for it.

module per_key_leaky_bucket_limiter
  import plbl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,   // [63:0] request_key, [95:64] now_ms
  input  logic          s_axis_tuser,   // [0] key_present
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [71:0]   m_axis_tdata,   // [2:0] verdict, [32:3] excess_out,
                                        // [64:33] delay_ms, [71:65] zero
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [31:0]         last;
    logic [29:0]         excess;
    logic [IDX_W-1:0]    newer;
    logic [IDX_W-1:0]    older;
  } ent_t;

  typedef struct packed {
    logic data;
    logic newer;
    logic older;
  } wmask_t;

  // Configuration registers.
  logic        enabled_q;
  logic [29:0] rate_q;
  logic [29:0] burst_q;
  logic        no_delay_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      rate_q     <= 30'd1000;
      burst_q    <= 30'd0;
      no_delay_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_ENABLED:  enabled_q  <= pwdata[0];
        REG_RATE:     rate_q     <= pwdata[29:0];
        REG_BURST:    burst_q    <= pwdata[29:0];
        REG_NO_DELAY: no_delay_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_ENABLED:  prdata = {31'd0, enabled_q};
      REG_RATE:     prdata = {2'd0, rate_q};
      REG_BURST:    prdata = {2'd0, burst_q};
      REG_NO_DELAY: prdata = {31'd0, no_delay_q};
      default:      prdata = '0;
    endcase
  end

  // Sequencer and datapath registers.
  state_e              state_q, state_d;
  logic [KEY_BITS-1:0] key_q;
  logic [31:0]         now_q;
  logic [1:0]          round_q;
  logic                forced_q;
  logic [CNT_W-1:0]    scan_q;
  logic                cmp_live_q;
  logic [IDX_W-1:0]    cmp_idx_q;
  logic                free_found_q;
  logic [IDX_W-1:0]    free_idx_q;
  logic [IDX_W-1:0]    slot_q;
  logic [31:0]         hit_last_q;
  logic [29:0]         hit_excess_q;
  logic [IDX_W-1:0]    hit_newer_q;
  logic [IDX_W-1:0]    hit_older_q;
  logic [61:0]         prod_q;
  logic [39:0]         ex1000_q;
  logic [40:0]         full1k_q;
  logic [39:0]         z_q;
  logic [10:0]         q1_q;
  logic [29:0]         zr_q;
  logic [30:0]         e_q;
  logic [63:0]         dq_q;
  logic [29:0]         rem_q;
  logic [29:0]         dvs_q;
  logic [5:0]          dcnt_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0]    newest_q;
  logic [IDX_W-1:0]    oldest_q;
  logic [CNT_W-1:0]    used_q;
  verdict_e            res_verdict_q;
  logic [29:0]         res_excess_q;
  logic [31:0]         res_delay_q;
  logic                m_valid_q;
  logic [71:0]         m_data_q;

  // Entry memory with write enables for the data fields and for each link, and a registered read.
  ent_t             mem_q [TABLE_ENTRIES];
  ent_t             rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  wmask_t           wr_en;
  ent_t             wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en.data) begin
      mem_q[wr_addr].key    <= wr_data.key;
      mem_q[wr_addr].last   <= wr_data.last;
      mem_q[wr_addr].excess <= wr_data.excess;
    end
    if (wr_en.newer) begin
      mem_q[wr_addr].newer <= wr_data.newer;
    end
    if (wr_en.older) begin
      mem_q[wr_addr].older <= wr_data.older;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Shared combinational terms.
  logic        in_acc;
  logic        out_free;
  logic [31:0] exp_el;
  logic        scan_hit;
  logic        div_done;
  logic [30:0] full_w;
  logic [40:0] q1_prod_w;
  logic [20:0] q1k_w;
  logic [19:0] r1_w;
  logic [60:0] q2_prod_w;
  logic [30:0] e_w;
  logic [30:0] div_t;
  logic        div_ge;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;
  assign exp_el        = elapsed_abs(now_q, rd_data_q.last);
  assign scan_hit      = cmp_live_q & valid_q[cmp_idx_q] & (rd_data_q.key == key_q);
  assign div_done      = (dcnt_q == 6'd63);
  assign full_w        = 31'(hit_excess_q) + 31'(ONE_REQ);
  // The new excess is floor(z / 1000), split into a high and a low step.
  assign q1_prod_w     = 41'(z_q[39:20]) * 41'(RECIP_HI);
  assign q1k_w         = 21'(q1_q) * 21'(ONE_REQ);
  assign r1_w          = z_q[39:20] - q1k_w[19:0];
  assign q2_prod_w     = 61'(zr_q) * 61'(RECIP_LO);
  assign e_w           = {q1_q, q2_prod_w[59:40]};
  assign div_t         = {rem_q, dq_q[63]};
  assign div_ge        = (div_t >= {1'b0, dvs_q});

  // Next state, memory addresses and memory writes.
  always_comb begin
    state_d = state_q;
    rd_addr = oldest_q;
    wr_addr = slot_q;
    wr_en   = '0;
    wr_data = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (enabled_q && s_axis_tuser) ? ST_EXP_BEGIN : ST_OUT;
        end
      end
      ST_EXP_BEGIN: begin
        if (used_q == '0) begin
          state_d = forced_q ? ST_INSERT : ST_SCAN;
        end else begin
          state_d = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        if (round_q == 2'd0) begin
          state_d = (round_q + 2'd1 < EXPIRE_ROUNDS) ? ST_EXP_BEGIN : ST_INSERT;
        end else if (exp_el < IDLE_MS) begin
          state_d = forced_q ? ST_INSERT : ST_SCAN;
        end else begin
          state_d = ST_EXP_CMP;
        end
      end
      ST_EXP_CMP: begin
        if (62'(ex1000_q) > prod_q) begin
          state_d = forced_q ? ST_INSERT : ST_SCAN;
        end else if (round_q + 2'd1 < EXPIRE_ROUNDS) begin
          state_d = ST_EXP_BEGIN;
        end else begin
          state_d = forced_q ? ST_INSERT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_addr = scan_q[IDX_W-1:0];
        if (scan_hit) begin
          state_d = ST_HIT_MUL;
        end else if (cmp_live_q && cmp_idx_q == LAST_IDX) begin
          state_d = (used_q >= ENTRIES_C) ? ST_EXP_BEGIN : ST_INSERT;
        end
      end
      ST_HIT_MUL:   state_d = ST_HIT_Z;
      ST_HIT_Z:     state_d = ST_HIT_Q1;
      ST_HIT_Q1:    state_d = ST_HIT_Q2;
      ST_HIT_Q2:    state_d = ST_HIT_E;
      ST_DIV_LOAD:  state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DELAY_END;
        end
      end
      ST_HIT_E:     state_d = ST_TOUCH_A;
      ST_TOUCH_A: begin
        if (slot_q == newest_q) begin
          state_d = ST_DECIDE;
        end else if (slot_q == oldest_q) begin
          state_d = ST_TOUCH_C;
        end else begin
          wr_addr       = hit_newer_q;
          wr_en.older   = 1'b1;
          wr_data.older = hit_older_q;
          state_d       = ST_TOUCH_B;
        end
      end
      ST_TOUCH_B: begin
        wr_addr       = hit_older_q;
        wr_en.newer   = 1'b1;
        wr_data.newer = hit_newer_q;
        state_d       = ST_TOUCH_C;
      end
      ST_TOUCH_C: begin
        wr_addr       = slot_q;
        wr_en.older   = 1'b1;
        wr_data.older = newest_q;
        state_d       = ST_TOUCH_D;
      end
      ST_TOUCH_D: begin
        wr_addr       = newest_q;
        wr_en.newer   = 1'b1;
        wr_data.newer = slot_q;
        state_d       = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (e_q > 31'(burst_q)) begin
          state_d = ST_OUT;
        end else begin
          wr_addr        = slot_q;
          wr_en.data     = 1'b1;
          wr_data.key    = key_q;
          wr_data.last   = now_q;
          wr_data.excess = e_q[29:0];
          if (e_q == '0 || no_delay_q || rate_q == '0) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_DELAY_MUL;
          end
        end
      end
      ST_DELAY_MUL: state_d = ST_DIV_LOAD;
      ST_DELAY_END: state_d = ST_OUT;
      ST_INSERT: begin
        wr_addr        = free_idx_q;
        wr_en.data     = 1'b1;
        wr_en.older    = 1'b1;
        wr_data.key    = key_q;
        wr_data.last   = now_q;
        wr_data.excess = '0;
        wr_data.older  = newest_q;
        state_d        = (used_q == '0) ? ST_OUT : ST_INSERT_LINK;
      end
      ST_INSERT_LINK: begin
        wr_addr       = newest_q;
        wr_en.newer   = 1'b1;
        wr_data.newer = free_idx_q;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Table bookkeeping: valid bits, recency ends and fill count.
  logic retire_now;
  assign retire_now = ((state_q == ST_EXP_CHK) && (round_q == 2'd0)) ||
                      ((state_q == ST_EXP_CMP) && (62'(ex1000_q) <= prod_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      newest_q     <= '0;
      oldest_q     <= '0;
      used_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      // The oldest entry leaves; its newer neighbor becomes the oldest.
      if (retire_now) begin
        valid_q[oldest_q] <= 1'b0;
        used_q            <= used_q - CNT_W'(1);
        if (oldest_q != newest_q) begin
          oldest_q <= rd_data_q.newer;
        end
        if (!free_found_q || oldest_q < free_idx_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= oldest_q;
        end
      end
      // Lowest free slot seen by the scan.
      if (state_q == ST_EXP_BEGIN && state_d == ST_SCAN) begin
        free_found_q <= 1'b0;
      end
      if ((state_q == ST_EXP_CHK || state_q == ST_EXP_CMP) && state_d == ST_SCAN) begin
        free_found_q <= 1'b0;
      end
      if (state_q == ST_SCAN && cmp_live_q && !valid_q[cmp_idx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= cmp_idx_q;
      end
      // Recency list updates on a hit.
      if (state_q == ST_TOUCH_A && slot_q != newest_q && slot_q == oldest_q) begin
        oldest_q <= hit_newer_q;
      end
      if (state_q == ST_TOUCH_D) begin
        newest_q <= slot_q;
      end
      // New entry; the old newest keeps its place until it is linked.
      if (state_q == ST_INSERT) begin
        valid_q[free_idx_q] <= 1'b1;
        used_q              <= used_q + CNT_W'(1);
        if (used_q == '0) begin
          newest_q <= free_idx_q;
          oldest_q <= free_idx_q;
        end
      end
      if (state_q == ST_INSERT_LINK) begin
        newest_q <= free_idx_q;
      end
      // Output register.
      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request control counters: expiry rounds, scan position and divider steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q    <= '0;
      forced_q   <= 1'b0;
      scan_q     <= '0;
      cmp_live_q <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          round_q  <= 2'd1;
          forced_q <= 1'b0;
        end
        ST_EXP_CHK: begin
          if (round_q == 2'd0) begin
            round_q <= round_q + 2'd1;
          end
        end
        ST_EXP_CMP: begin
          round_q <= round_q + 2'd1;
        end
        ST_SCAN: begin
          cmp_live_q <= (scan_q < ENTRIES_C);
          scan_q     <= scan_q + CNT_W'(1);
          if (state_d == ST_EXP_BEGIN) begin
            forced_q <= 1'b1;
            round_q  <= 2'd0;
          end
        end
        ST_DIV_LOAD: begin
          dcnt_q <= '0;
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 6'd1;
        end
        default: ;
      endcase
      if (state_d == ST_SCAN && state_q != ST_SCAN) begin
        scan_q     <= '0;
        cmp_live_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        key_q         <= s_axis_tdata[KEY_BITS-1:0];
        now_q         <= s_axis_tdata[95:64];
        res_verdict_q <= VERDICT_SKIP;
        res_excess_q  <= '0;
        res_delay_q   <= '0;
      end
      ST_EXP_CHK: begin
        prod_q   <= 62'(rate_q) * 62'(exp_el);
        ex1000_q <= 40'(rd_data_q.excess) * 40'(ONE_REQ);
      end
      ST_SCAN: begin
        cmp_idx_q    <= scan_q[IDX_W-1:0];
        slot_q       <= cmp_idx_q;
        hit_last_q   <= rd_data_q.last;
        hit_excess_q <= rd_data_q.excess;
        hit_newer_q  <= rd_data_q.newer;
        hit_older_q  <= rd_data_q.older;
      end
      ST_HIT_MUL: begin
        prod_q   <= 62'(rate_q) * 62'(elapsed_abs(now_q, hit_last_q));
        full1k_q <= 41'(full_w) * 41'(ONE_REQ);
      end
      // The excess left after draining is ceil((full*1000 - drain)/1000), or zero if the drain covers it.
      ST_HIT_Z: begin
        if (62'(full1k_q) > prod_q) begin
          z_q <= 40'(62'(full1k_q) - prod_q + 62'd999);
        end else begin
          z_q <= '0;
        end
      end
      ST_HIT_Q1: begin
        q1_q <= q1_prod_w[40:30];
      end
      ST_HIT_Q2: begin
        zr_q <= {r1_w[9:0], z_q[19:0]};
      end
      ST_DIV_LOAD: begin
        dq_q  <= 64'(prod_q);
        rem_q <= '0;
        dvs_q <= rate_q;
      end
      ST_DIV: begin
        rem_q <= div_ge ? 30'(div_t - {1'b0, dvs_q}) : div_t[29:0];
        dq_q  <= {dq_q[62:0], div_ge};
      end
      ST_HIT_E: begin
        e_q          <= e_w;
        res_excess_q <= (e_w > 31'(W30_MAX)) ? W30_MAX : e_w[29:0];
      end
      ST_DECIDE: begin
        if (e_q > 31'(burst_q)) begin
          res_verdict_q <= VERDICT_REJECT;
        end else if (e_q == '0) begin
          res_verdict_q <= VERDICT_PASS;
        end else if (no_delay_q) begin
          res_verdict_q <= VERDICT_NODLY;
        end else begin
          res_verdict_q <= VERDICT_DELAY;
          res_delay_q   <= DELAY_MAX;
        end
      end
      ST_DELAY_MUL: begin
        prod_q <= 62'(41'(e_q) * 41'(ONE_REQ));
      end
      ST_DELAY_END: begin
        res_delay_q <= (dq_q[63:32] != '0) ? DELAY_MAX : dq_q[31:0];
      end
      ST_INSERT: begin
        res_verdict_q <= VERDICT_NEW;
      end
      ST_OUT: begin
        if (out_free) begin
          m_data_q <= {7'd0, res_delay_q, res_excess_q, res_verdict_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ----- rtl/core/plbl_checker.sv -----
`timescale 1ns / 1ps

module plbl_checker
  import plbl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // Only defined verdict codes leave the block.
  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= VERDICT_REJECT)
    else $error("undefined verdict code");

  // A delay value is only carried with a delay verdict.
  a_delay_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != VERDICT_DELAY) |-> m_axis_tdata[64:33] == '0)
    else $error("delay set without delay verdict");

  // Skipped requests and new entries report no excess.
  a_excess_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[2:0] == VERDICT_SKIP ||
                       m_axis_tdata[2:0] == VERDICT_NEW)) |-> m_axis_tdata[32:3] == '0)
    else $error("excess reported on skip or new entry");

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted back to back");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind per_key_leaky_bucket_limiter plbl_checker u_plbl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
